@@ hdl/roulette_wheel_selector_defines.svh @@
// Assertion macros for the roulette wheel selector checker.
// Depends on nothing; expects clk_i and rst_ni in the scope of use.
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("roulette wheel selector check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define RWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("roulette wheel selector check failed");

`endif

@@ hdl/rws_pkg.sv @@
// Shared types and constants for the roulette wheel selector.
// Depends on nothing; used by every module of the block.
package rws_pkg;

  // Table sizing
  localparam int PopSize = 256;
  localparam int AddrW   = $clog2(PopSize);
  localparam int CntW    = $clog2(PopSize + 1);
  localparam int CumW    = 24;
  localparam int FitW    = 16;
  localparam int FracW   = 16;
  localparam int GoalW   = CumW + FracW;
  localparam int IdxW    = 8;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_SELECT = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  // Source of the result index
  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_COUNT = 2'd1,
    RES_LO    = 2'd2
  } res_src_e;

  // Controller states
  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_READ = 2'd1,
    CTL_CMP  = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [FitW-1:0]  fitness_value;
    logic [FracW-1:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] chosen_index;
    status_e         status;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     clear;
    logic     load;
    logic     init;
    logic     rd;
    logic     step;
    logic     res_en;
    res_src_e res_src;
    status_e  res_status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic total_zero;
    logic more;
  } dp_stat_t;

endpackage

@@ hdl/rws_datapath.sv @@
// Datapath of the roulette wheel selector: cumulative table memory, count,
// running total, search bounds and result register. Depends on rws_pkg.
module rws_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rws_pkg::in_item_t   item_i,
  input  rws_pkg::dp_cmd_t    cmd_i,
  output rws_pkg::dp_stat_t   stat_o,
  output rws_pkg::out_item_t  result_o
);

  logic [rws_pkg::CumW-1:0]  mem_q [rws_pkg::PopSize];
  logic [rws_pkg::CntW-1:0]  count_q, count_d;
  logic [rws_pkg::CumW-1:0]  total_q, total_d;
  logic [rws_pkg::GoalW-1:0] goal_q;
  logic [rws_pkg::AddrW-1:0] lo_q, lo_d, hi_q, hi_d, mid;
  logic [rws_pkg::CumW-1:0]  rd_data_q;
  rws_pkg::out_item_t        result_q, result_d;
  logic [rws_pkg::CumW:0]    sum_wide;
  logic [rws_pkg::CumW-1:0]  sum_sat;
  logic [rws_pkg::GoalW-1:0] cum_scaled;
  logic                      cum_ge;

  // Saturating add of the new fitness to the running total
  assign sum_wide = {1'b0, total_q} + (rws_pkg::CumW + 1)'(item_i.fitness_value);
  assign sum_sat  = sum_wide[rws_pkg::CumW] ? {rws_pkg::CumW{1'b1}}
                                            : sum_wide[rws_pkg::CumW-1:0];

  // Probe point halfway between the bounds
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Scale the entry by 65535 as (x << 16) - x and test against the goal
  assign cum_scaled = {rd_data_q, {rws_pkg::FracW{1'b0}}}
                    - rws_pkg::GoalW'(rd_data_q);
  assign cum_ge     = (cum_scaled >= goal_q);

  // Status toward the controller
  assign stat_o.full       = (count_q == rws_pkg::CntW'(rws_pkg::PopSize));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.total_zero = (total_q == '0);
  assign stat_o.more       = (lo_q < hi_q);

  // Next count and total
  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.clear) begin
      count_d = '0;
      total_d = '0;
    end else if (cmd_i.load) begin
      count_d = count_q + 1'b1;
      total_d = sum_sat;
    end
  end

  // Next search bounds
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.init) begin
      lo_d = '0;
      hi_d = rws_pkg::AddrW'(count_q - 1'b1);
    end else if (cmd_i.step) begin
      if (cum_ge) begin
        hi_d = mid;
      end else begin
        lo_d = mid + 1'b1;
      end
    end
  end

  // Next result item
  always_comb begin
    result_d        = result_q;
    result_d.status = cmd_i.res_status;
    case (cmd_i.res_src)
      rws_pkg::RES_COUNT: result_d.chosen_index = rws_pkg::IdxW'(count_q);
      rws_pkg::RES_LO:    result_d.chosen_index = rws_pkg::IdxW'(lo_q);
      default:            result_d.chosen_index = '0;
    endcase
  end

  // Hold count and total across items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[rws_pkg::AddrW'(count_q)] <= sum_sat;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[mid];
    end
  end

  // Search registers and result
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.init) begin
      goal_q <= item_i.random_fraction * total_q;
    end
    if (cmd_i.res_en) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

@@ hdl/rws_ctrl.sv @@
// Controller of the roulette wheel selector: decodes items and sequences
// the binary search over the table. Depends on rws_pkg.
module rws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        func_i,
  input  rws_pkg::dp_stat_t stat_i,
  output rws_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  rws_pkg::ctl_state_e state_q, state_d;
  logic                done_q, done_d;

  // State and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rws_pkg::CTL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d           = state_q;
    done_d            = 1'b0;
    cmd_o             = '0;
    cmd_o.res_src     = rws_pkg::RES_ZERO;
    cmd_o.res_status  = rws_pkg::ST_OK;
    case (state_q)
      rws_pkg::CTL_IDLE: begin
        if (start_i) begin
          cmd_o.res_en = 1'b1;
          done_d       = 1'b1;
          case (func_i)
            rws_pkg::FUNC_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            rws_pkg::FUNC_LOAD: begin
              if (stat_i.full) begin
                cmd_o.res_status = rws_pkg::ST_FULL;
              end else begin
                cmd_o.load    = 1'b1;
                cmd_o.res_src = rws_pkg::RES_COUNT;
              end
            end
            rws_pkg::FUNC_SELECT: begin
              if (stat_i.empty || stat_i.total_zero) begin
                cmd_o.res_status = rws_pkg::ST_NONE;
              end else begin
                // start the search, result comes later
                cmd_o.res_en = 1'b0;
                done_d       = 1'b0;
                cmd_o.init   = 1'b1;
                state_d      = rws_pkg::CTL_READ;
              end
            end
            default: begin
              // unused code: report ok, change nothing
            end
          endcase
        end
      end
      rws_pkg::CTL_READ: begin
        if (stat_i.more) begin
          cmd_o.rd = 1'b1;
          state_d  = rws_pkg::CTL_CMP;
        end else begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_src = rws_pkg::RES_LO;
          done_d        = 1'b1;
          state_d       = rws_pkg::CTL_IDLE;
        end
      end
      rws_pkg::CTL_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = rws_pkg::CTL_READ;
      end
      default: begin
        state_d = rws_pkg::CTL_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != rws_pkg::CTL_IDLE);
  assign done_o = done_q;

endmodule

@@ hdl/roulette_wheel_selector.sv @@
// Top level of the roulette wheel selector: controller plus datapath.
// Depends on rws_pkg, rws_ctrl and rws_datapath.
//
//   channel   handshake                  payload
//   item in   start_i high, busy_o low   item_i   (rws_pkg::in_item_t)
//   result    done_o high for one cycle  result_o (rws_pkg::out_item_t)
//
// Clear, load and a select that finds nothing show their result in the
// cycle after the item is taken. A select over n entries runs a binary
// search to its result, with one table read and one compare per search step.
// Reset clears the entry count and running total; the table needs no clear.
// The receiver cannot stall; a new item may be taken while a result shows.
module roulette_wheel_selector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rws_pkg::in_item_t  item_i,
  output logic               busy_o,
  output logic               done_o,
  output rws_pkg::out_item_t result_o
);

  rws_pkg::dp_cmd_t  cmd;
  rws_pkg::dp_stat_t stat;

  rws_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .func_i (item_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  rws_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .result_o(result_o)
  );

endmodule

@@ hdl/rws_checker.sv @@
// Port-level checks for the roulette wheel selector, bound to the top level.
// Depends on rws_pkg and roulette_wheel_selector_defines.svh.
`include "roulette_wheel_selector_defines.svh"

module rws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_i,
  input logic               done_i,
  input rws_pkg::out_item_t result_i
);

  // An accepted item either reports at once or keeps the block busy
  `RWS_ASSERT_NXT(a_accept_progress, start_i && !busy_i, busy_i || done_i)

  // A result never shows while a search is still running
  `RWS_ASSERT_IMP(a_done_not_busy, done_i, !busy_i)

  // A result follows an accepted item or the end of a search
  `RWS_ASSERT_IMP(a_done_has_cause, done_i, $past(busy_i) || $past(start_i))

  // Error results always carry index zero
  `RWS_ASSERT_IMP(a_error_index_zero,
    done_i && (result_i.status == rws_pkg::ST_FULL || result_i.status == rws_pkg::ST_NONE),
    result_i.chosen_index == '0)

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .done_i  (done_o),
  .result_i(result_o)
);

@@ bench/rws_wheel_checker.sv @@
// Checker for the roulette wheel selector: watches the item and result channels,
// predicts every result from its own copy of the table and compares in order.
// Depends on rws_pkg for the item types, operation codes and status codes.
module rws_wheel_checker
  import rws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  in_item_t  item_i,
  input  logic      done_i,
  input  out_item_t result_i,
  output int        pending_o,
  output int        errors_o
);

  localparam logic [CumW-1:0]  CumMax  = {CumW{1'b1}};
  localparam logic [GoalW-1:0] FracOne = GoalW'(65535);

  // Shadow of the wheel: cumulative sums, entry count and total
  logic [CumW-1:0] wheel_cum [PopSize];
  logic [CntW-1:0] slot_count;
  logic [CumW-1:0] wheel_total;

  out_item_t wheel_outcomes[$];
  int        mismatches;

  // Apply one item to the shadow wheel and return the result it causes
  function automatic out_item_t spin_wheel(input in_item_t it);
    out_item_t       res;
    logic [CumW:0]   sum;
    logic [GoalW-1:0] goal;
    logic [GoalW-1:0] reach;
    int              hit;
    res.chosen_index = '0;
    res.status       = ST_OK;
    case (it.func)
      FUNC_CLEAR: begin
        slot_count  = '0;
        wheel_total = '0;
      end
      FUNC_LOAD: begin
        if (slot_count >= PopSize) begin
          res.status = ST_FULL;
        end else begin
          sum = {1'b0, wheel_total} + (CumW + 1)'(it.fitness_value);
          if (sum > {1'b0, CumMax}) sum = {1'b0, CumMax};
          wheel_total                        = sum[CumW-1:0];
          wheel_cum[slot_count[AddrW-1:0]]   = sum[CumW-1:0];
          res.chosen_index                   = slot_count[IdxW-1:0];
          slot_count                         = slot_count + 1'b1;
        end
      end
      FUNC_SELECT: begin
        if (slot_count == 0 || wheel_total == 0) begin
          res.status = ST_NONE;
        end else begin
          // first entry whose share of the wheel reaches the fraction
          goal = GoalW'(it.random_fraction) * GoalW'(wheel_total);
          hit  = int'(slot_count) - 1;
          for (int i = int'(slot_count) - 1; i >= 0; i--) begin
            reach = GoalW'(wheel_cum[i]) * FracOne;
            if (reach >= goal) hit = i;
          end
          res.chosen_index = hit[IdxW-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Compare each result with the oldest prediction, then record new items
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      slot_count  = '0;
      wheel_total = '0;
      mismatches  = 0;
      wheel_outcomes.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (done_i) begin
        if (wheel_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %0d status %0d",
                     result_i.chosen_index, result_i.status);
        end else begin
          want = wheel_outcomes.pop_front();
          if (result_i.chosen_index !== want.chosen_index ||
              result_i.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected index %0d status %0d, got index %0d status %0d",
                       want.chosen_index, want.status,
                       result_i.chosen_index, result_i.status);
          end
        end
      end
      if (start_i && !busy_i) wheel_outcomes.push_back(spin_wheel(item_i));
      pending_o <= wheel_outcomes.size();
      errors_o  <= mismatches;
    end
  end

endmodule

@@ bench/testbench.sv @@
// Top of the roulette wheel selector bench: clock, reset, item stimulus and verdict.
// Depends on rws_pkg, roulette_wheel_selector and rws_wheel_checker.
module testbench;
  import rws_pkg::*;

  // Function code with no operation behind it
  localparam logic [1:0] FuncSpare = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  in_item_t  item_i;
  logic      busy_o;
  logic      done_o;
  out_item_t result_o;
  int        pending;
  int        errors;

  int   items_sent;
  logic burst;

  roulette_wheel_selector DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  rws_wheel_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_i    (busy_o),
    .item_i    (item_i),
    .done_i    (done_o),
    .result_i  (result_o),
    .pending_o (pending),
    .errors_o  (errors)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst) return 0;
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic logic [FitW-1:0] pick_fitness();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return FitW'($urandom_range(0, 1023));
      default: return FitW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [FracW-1:0] pick_fraction();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return FracW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one item, hold it until taken, then idle for a random gap
  task automatic feed(input logic [1:0] f, input logic [FitW-1:0] fit,
                      input logic [FracW-1:0] frac);
    in_item_t it;
    int       gap;
    it.func            = f;
    it.fitness_value   = fit;
    it.random_fraction = frac;
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      item_i  <= in_item_t'($urandom());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted result has come back
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int loads;
    int picks;
    int episode;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    item_i     = '0;
    items_sent = 0;
    burst      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, zero total, zero-fitness head, extremes, spare code
    feed(FUNC_SELECT, 16'h0000, 16'd12345);
    feed(FuncSpare,   16'h0000, 16'h0000);
    feed(FUNC_LOAD,   16'h0000, 16'hFFFF);
    feed(FUNC_SELECT, 16'hFFFF, 16'h0000);
    feed(FUNC_SELECT, 16'h0000, 16'hFFFF);
    feed(FUNC_LOAD,   16'hFFFF, 16'h0000);
    feed(FUNC_LOAD,   16'h0000, 16'h0000);
    feed(FUNC_LOAD,   16'h0001, 16'h0000);
    feed(FUNC_SELECT, 16'h0000, 16'h0000);
    feed(FUNC_SELECT, 16'h0000, 16'hFFFF);
    feed(FUNC_SELECT, 16'h0000, 16'h8000);
    feed(FUNC_LOAD,   16'hAAAA, 16'hFFFF);
    feed(FuncSpare,   16'hFFFF, 16'hFFFF);
    feed(FUNC_SELECT, 16'hFFFF, 16'h0001);
    feed(FUNC_CLEAR,  16'hFFFF, 16'hFFFF);
    feed(FUNC_SELECT, 16'h0000, 16'h4000);
    feed(FUNC_LOAD,   16'h5555, 16'h5555);
    feed(FUNC_SELECT, 16'h0000, 16'hFFFF);
    feed(FUNC_CLEAR,  16'h0000, 16'h0000);
    drain();

    // Random: episodes of clear, a run of loads, then selects, with noise
    episode = 0;
    while (items_sent < 390) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) != 0)
        feed(FUNC_CLEAR, FitW'($urandom()), FracW'($urandom()));
      if (episode == 2) loads = PopSize + 2;
      else if ($urandom_range(0, 5) == 0) loads = $urandom_range(13, 40);
      else loads = $urandom_range(1, 12);
      for (int i = 0; i < loads; i++) begin
        if ($urandom_range(0, 15) == 0)
          feed(FuncSpare, FitW'($urandom()), FracW'($urandom()));
        feed(FUNC_LOAD, pick_fitness(), FracW'($urandom()));
      end
      picks = $urandom_range(1, 8);
      for (int i = 0; i < picks; i++) begin
        if ($urandom_range(0, 9) == 0)
          feed(FUNC_LOAD, pick_fitness(), FracW'($urandom()));
        feed(FUNC_SELECT, FitW'($urandom()), pick_fraction());
      end
      if (episode % 6 == 5) drain();
      episode++;
    end

    // Let the last results arrive, then give the verdict
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
